/* src/jsu_pkg.sv */
// Shared types, codes and UTF-8 helpers for the JSON string unescape block.
package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CP_W = 21;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_CTRL    = 3'd1;
  localparam logic [2:0] ERR_ESC     = 3'd2;
  localparam logic [2:0] ERR_HEX     = 3'd3;
  localparam logic [2:0] ERR_END_ESC = 3'd4;
  localparam logic [2:0] ERR_END_HEX = 3'd5;
  localparam logic [2:0] ERR_UNTERM  = 3'd6;

  typedef enum logic [1:0] {
    TAIL_NONE  = 2'd0,
    TAIL_CLOSE = 2'd1,
    TAIL_ERR   = 2'd2
  } tail_t;

  typedef struct packed {
    logic            cp0_v;
    logic [CP_W-1:0] cp0;
    logic            cp1_v;
    logic            cp1_raw;
    logic [CP_W-1:0] cp1;
    tail_t           tail;
    logic [2:0]      code;
  } rec_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [8:0] esc_map(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] utf8_lenm1(input logic [CP_W-1:0] cp);
    logic [1:0] r;
    if (cp <= CP_W'(32'h7F)) begin
      r = 2'd0;
    end else if (cp <= CP_W'(32'h7FF)) begin
      r = 2'd1;
    end else if (cp <= CP_W'(32'hFFFF)) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [1:0] lenm1,
                                           input logic [1:0] idx);
    logic [7:0] r;
    r = 8'd0;
    case (lenm1)
      2'd0: r = cp[7:0];
      2'd1: begin
        case (idx)
          2'd0:    r = {3'b110, cp[10:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

/* src/jsu_front.sv */
// Front end: accepts raw bytes, runs the escape scanner and builds result records.
module jsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [7:0]      in_byte,
  input  logic            in_new_string,
  input  logic            in_end_of_input,
  input  logic            q_full,
  output logic            q_wr,
  output jsu_pkg::rec_t   q_rec
);

  typedef enum logic [4:0] {
    M_BODY = 5'b00001,
    M_ESC  = 5'b00010,
    M_HEX  = 5'b00100,
    M_DONE = 5'b01000,
    M_FAIL = 5'b10000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        bad_r, bad_nxt;
  logic [9:0]  held_r, held_nxt;
  logic        hv_r, hv_nxt;

  logic        accept;
  jsu_pkg::rec_t rec;

  always_comb begin
    mode_t       mode_c;
    logic [1:0]  cnt_c;
    logic [15:0] acc_c;
    logic        bad_c;
    logic [9:0]  held_c;
    logic        hv_c;
    logic [4:0]  hd;
    logic [8:0]  em;
    logic [15:0] acc_d;
    logic        bad_d;
    logic        fail_c;
    logic [2:0]  fcode;
    logic [jsu_pkg::CP_W-1:0] held_cp;

    mode_c = in_new_string ? M_BODY : mode_r;
    cnt_c  = in_new_string ? 2'd0 : cnt_r;
    acc_c  = in_new_string ? 16'd0 : acc_r;
    bad_c  = in_new_string ? 1'b0 : bad_r;
    held_c = in_new_string ? 10'd0 : held_r;
    hv_c   = in_new_string ? 1'b0 : hv_r;

    mode_nxt = mode_c;
    cnt_nxt  = cnt_c;
    acc_nxt  = acc_c;
    bad_nxt  = bad_c;
    held_nxt = held_c;
    hv_nxt   = hv_c;

    hd      = jsu_pkg::hex_digit(in_byte);
    em      = jsu_pkg::esc_map(in_byte);
    acc_d   = hd[4] ? {acc_c[11:0], hd[3:0]} : acc_c;
    bad_d   = bad_c | ~hd[4];
    held_cp = {5'b0, 6'b110110, held_c};
    fail_c  = 1'b0;
    fcode   = jsu_pkg::ERR_NONE;
    rec     = '0;

    unique case (mode_c)
      M_BODY: begin
        if (in_byte == 8'h22) begin
          rec.cp0_v = hv_c;
          rec.cp0   = held_cp;
          rec.tail  = jsu_pkg::TAIL_CLOSE;
          hv_nxt    = 1'b0;
          held_nxt  = 10'd0;
          mode_nxt  = M_DONE;
        end else if (in_byte < 8'h20) begin
          fail_c = 1'b1;
          fcode  = jsu_pkg::ERR_CTRL;
        end else if (in_byte == 8'h5C) begin
          mode_nxt = M_ESC;
        end else begin
          rec.cp0_v   = hv_c;
          rec.cp0     = held_cp;
          rec.cp1_v   = 1'b1;
          rec.cp1_raw = 1'b1;
          rec.cp1     = jsu_pkg::CP_W'(in_byte);
          hv_nxt      = 1'b0;
          held_nxt    = 10'd0;
        end
      end
      M_ESC: begin
        if (in_byte == 8'h75) begin
          mode_nxt = M_HEX;
          cnt_nxt  = 2'd0;
          acc_nxt  = 16'd0;
          bad_nxt  = 1'b0;
        end else if (!em[8]) begin
          fail_c = 1'b1;
          fcode  = jsu_pkg::ERR_ESC;
        end else begin
          rec.cp0_v = hv_c;
          rec.cp0   = held_cp;
          rec.cp1_v = 1'b1;
          rec.cp1   = jsu_pkg::CP_W'(em[7:0]);
          hv_nxt    = 1'b0;
          held_nxt  = 10'd0;
          mode_nxt  = M_BODY;
        end
      end
      M_HEX: begin
        acc_nxt = acc_d;
        bad_nxt = bad_d;
        if (cnt_c == 2'd3) begin
          mode_nxt = M_BODY;
          cnt_nxt  = 2'd0;
          if (bad_d) begin
            fail_c = 1'b1;
            fcode  = jsu_pkg::ERR_HEX;
          end else if (hv_c && acc_d >= 16'hDC00 && acc_d <= 16'hDFFF) begin
            rec.cp1_v = 1'b1;
            rec.cp1   = jsu_pkg::CP_W'(21'h10000) + {1'b0, held_c, acc_d[9:0]};
            hv_nxt    = 1'b0;
            held_nxt  = 10'd0;
          end else begin
            rec.cp0_v = hv_c;
            rec.cp0   = held_cp;
            if (acc_d >= 16'hD800 && acc_d <= 16'hDBFF) begin
              held_nxt = acc_d[9:0];
              hv_nxt   = 1'b1;
            end else begin
              rec.cp1_v = 1'b1;
              rec.cp1   = jsu_pkg::CP_W'(acc_d);
              hv_nxt    = 1'b0;
              held_nxt  = 10'd0;
            end
          end
        end else begin
          cnt_nxt = cnt_c + 2'd1;
        end
      end
      M_DONE, M_FAIL: begin
      end
      default: begin
      end
    endcase

    if (!fail_c && in_end_of_input &&
        (mode_nxt == M_BODY || mode_nxt == M_ESC || mode_nxt == M_HEX)) begin
      fail_c = 1'b1;
      if (mode_nxt == M_ESC) begin
        fcode = jsu_pkg::ERR_END_ESC;
      end else if (mode_nxt == M_HEX) begin
        fcode = jsu_pkg::ERR_END_HEX;
      end else begin
        fcode = jsu_pkg::ERR_UNTERM;
      end
    end

    if (fail_c) begin
      rec      = '0;
      rec.tail = jsu_pkg::TAIL_ERR;
      rec.code = fcode;
      hv_nxt   = 1'b0;
      held_nxt = 10'd0;
      mode_nxt = M_FAIL;
    end
  end

  assign accept = push & ~q_full;
  assign q_rec  = rec;
  assign q_wr   = accept & (rec.cp0_v | rec.cp1_v | (rec.tail != jsu_pkg::TAIL_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BODY;
      cnt_r  <= 2'd0;
      acc_r  <= 16'd0;
      bad_r  <= 1'b0;
      held_r <= 10'd0;
      hv_r   <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      bad_r  <= bad_nxt;
      held_r <= held_nxt;
      hv_r   <= hv_nxt;
    end
  end

endmodule

/* src/jsu_fifo.sv */
// Short record queue between the front end and the byte emitter.
module jsu_fifo #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  jsu_pkg::rec_t wr_data,
  input  logic          rd_en,
  output jsu_pkg::rec_t rd_data,
  output logic          nonempty,
  output logic          full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::rec_t slots_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] count_r;

  assign rd_data  = slots_r[rp_r];
  assign nonempty = (count_r != '0);
  assign full     = (count_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (rd_en) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> nonempty) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* src/jsu_back.sv */
// Back end: expands queued records into UTF-8 data, close and error words.
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  jsu_pkg::rec_t q_rec,
  input  logic          q_nonempty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_kind,
  output logic [2:0]    out_error_code,
  output logic          out_last
);

  typedef enum logic [2:0] {
    SEG_CP0  = 3'b001,
    SEG_CP1  = 3'b010,
    SEG_TAIL = 3'b100
  } seg_t;

  seg_t       seg_r, seg_nxt, cur_seg;
  logic [1:0] idx_r, idx_nxt;
  logic       out_v_r;
  logic [7:0] byte_r;
  logic [1:0] kind_r;
  logic [2:0] code_r;
  logic       last_r;

  logic [jsu_pkg::CP_W-1:0] cur_cp;
  logic [1:0] lenm1;
  logic       seg_done, rec_done, step;
  logic [7:0] w_byte;
  logic [1:0] w_kind;
  logic [2:0] w_code;

  always_comb begin
    if (seg_r == SEG_CP0 && q_rec.cp0_v) begin
      cur_seg = SEG_CP0;
    end else if (seg_r != SEG_TAIL && q_rec.cp1_v) begin
      cur_seg = SEG_CP1;
    end else begin
      cur_seg = SEG_TAIL;
    end
  end

  // pass raw body bytes through as one word
  assign cur_cp   = (cur_seg == SEG_CP0) ? q_rec.cp0 : q_rec.cp1;
  assign lenm1    = (cur_seg == SEG_CP1 && q_rec.cp1_raw) ? 2'd0 :
                    jsu_pkg::utf8_lenm1(cur_cp);
  assign seg_done = (cur_seg == SEG_TAIL) || (idx_r == lenm1);
  assign rec_done = seg_done && ((cur_seg == SEG_TAIL) ||
                    ((q_rec.tail == jsu_pkg::TAIL_NONE) &&
                     ((cur_seg == SEG_CP1) || !q_rec.cp1_v)));
  assign step     = q_nonempty && (!out_v_r || pop);
  assign q_pop    = step && rec_done;

  always_comb begin
    w_byte = 8'd0;
    w_kind = jsu_pkg::KIND_DATA;
    w_code = jsu_pkg::ERR_NONE;
    if (cur_seg == SEG_TAIL) begin
      case (q_rec.tail)
        jsu_pkg::TAIL_CLOSE: w_kind = jsu_pkg::KIND_CLOSE;
        default: begin
          w_kind = jsu_pkg::KIND_ERR;
          w_code = q_rec.code;
        end
      endcase
    end else begin
      w_byte = jsu_pkg::utf8_byte(cur_cp, lenm1, idx_r);
    end
  end

  always_comb begin
    seg_nxt = seg_r;
    idx_nxt = idx_r;
    if (step) begin
      if (rec_done) begin
        seg_nxt = SEG_CP0;
        idx_nxt = 2'd0;
      end else if (seg_done) begin
        seg_nxt = (cur_seg == SEG_CP0) ? SEG_CP1 : SEG_TAIL;
        idx_nxt = 2'd0;
      end else begin
        seg_nxt = cur_seg;
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r   <= SEG_CP0;
      idx_r   <= 2'd0;
      out_v_r <= 1'b0;
    end else begin
      seg_r <= seg_nxt;
      idx_r <= idx_nxt;
      if (step) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_r <= w_byte;
      kind_r <= w_kind;
      code_r <= w_code;
      last_r <= rec_done;
    end
  end

  assign empty          = ~out_v_r;
  assign out_byte       = byte_r;
  assign out_kind       = kind_r;
  assign out_error_code = code_r;
  assign out_last       = last_r;

`ifndef SYNTH
  a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && kind_r != jsu_pkg::KIND_DATA |-> last_r)
    else $error("close or error word not marked last");
  a_code_only_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && kind_r != jsu_pkg::KIND_ERR |-> code_r == jsu_pkg::ERR_NONE)
    else $error("error code on a non-error word");
  a_term_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && kind_r != jsu_pkg::KIND_DATA |-> byte_r == 8'd0)
    else $error("nonzero byte on close or error word");
`endif

endmodule

/* src/json_string_unescape_top.sv */
// Top level of the JSON string unescape block.
// Takes the body bytes of a JSON string (after the opening quote) one per cycle and
// returns decoded UTF-8 bytes, a close word on the closing quote, or one error word;
// out_last marks the final word caused by an input byte. A byte is taken every cycle
// while the record queue has room; the emitter hands out one result word per cycle
// while the receiver pops, so a byte gives one word on plain text and up to six words
// when it completes a surrogate pair or flushes a lone surrogate. Bytes that give no
// result (a backslash, hex digits before the fourth) write no record and use no output
// word. A byte's words pass through the record queue and then the output register.
module json_string_unescape_top #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_new_string,
  input  logic       in_end_of_input,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  jsu_pkg::rec_t wr_rec, rd_rec;
  logic          q_wr, q_rd, q_nonempty, q_full;

  assign full = q_full;

  jsu_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .in_byte         (in_byte),
    .in_new_string   (in_new_string),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .q_wr            (q_wr),
    .q_rec           (wr_rec)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_data  (wr_rec),
    .rd_en    (q_rd),
    .rd_data  (rd_rec),
    .nonempty (q_nonempty),
    .full     (q_full)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rec          (rd_rec),
    .q_nonempty     (q_nonempty),
    .q_pop          (q_rd),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the JSON string unescape block: directed and random byte streams.
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [2:0] {
    SCAN_BODY,
    SCAN_ESC,
    SCAN_HEX,
    SCAN_DONE,
    SCAN_FAIL
  } scan_mode_t;

  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
    logic       last;
  } word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_new_string = 1'b0;
  logic       in_end_of_input = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] out_error_code;
  logic       out_last;

  // decoder state mirrored from the block
  scan_mode_t  scan_mode;
  logic [1:0]  hex_count;
  logic [15:0] hex_accum;
  logic        hex_bad;
  logic [9:0]  held_unit;
  logic        held_v;

  word_t       step_words[$];
  word_t       pending_words[$];
  logic [7:0]  string_bytes[$];
  int          live_items = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;

  json_string_unescape_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .in_new_string  (in_new_string),
    .in_end_of_input(in_end_of_input),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    string_bytes.insert(string_bytes.size(), b);
  endfunction

  function automatic void clear_decoder();
    scan_mode = SCAN_BODY;
    hex_count = 2'd0;
    hex_accum = 16'h0000;
    hex_bad   = 1'b0;
    held_unit = 10'd0;
    held_v    = 1'b0;
  endfunction

  function automatic void emit_word(input logic [7:0] d, input logic [1:0] k,
                                    input logic [2:0] c);
    word_t w;
    w.data = d;
    w.kind = k;
    w.code = c;
    w.last = 1'b0;
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void emit_codepoint(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit_word(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      emit_word({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      emit_word({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      emit_word({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      emit_word({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      emit_word({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end else begin
      emit_word({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      emit_word({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      emit_word({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      emit_word({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end
  endfunction

  function automatic void flush_held();
    if (held_v) begin
      emit_codepoint({5'd0, 6'b110110, held_unit});
      held_v    = 1'b0;
      held_unit = 10'd0;
    end
  endfunction

  function automatic void abort(input logic [2:0] c);
    step_words.delete();
    held_v    = 1'b0;
    held_unit = 10'd0;
    scan_mode = SCAN_FAIL;
    emit_word(8'h00, jsu_pkg::KIND_ERR, c);
  endfunction

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void finish_unit();
    logic [20:0] cp;
    scan_mode = SCAN_BODY;
    hex_count = 2'd0;
    if (hex_bad) begin
      abort(jsu_pkg::ERR_HEX);
    end else if (held_v && hex_accum >= 16'hDC00 && hex_accum <= 16'hDFFF) begin
      cp = 21'h10000 + 21'({held_unit, hex_accum[9:0]});
      held_v    = 1'b0;
      held_unit = 10'd0;
      emit_codepoint(cp);
    end else begin
      flush_held();
      if (hex_accum >= 16'hD800 && hex_accum <= 16'hDBFF) begin
        held_unit = hex_accum[9:0];
        held_v    = 1'b1;
      end else begin
        emit_codepoint({5'd0, hex_accum});
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic ns, input logic eoi);
    int         d;
    logic [8:0] mapped;
    if (ns) clear_decoder();
    if (scan_mode == SCAN_DONE || scan_mode == SCAN_FAIL) return;
    live_items++;
    step_words.delete();
    case (scan_mode)
      SCAN_BODY: begin
        if (b == CH_QUOTE) begin
          flush_held();
          emit_word(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE);
          scan_mode = SCAN_DONE;
        end else if (b < 8'h20) begin
          abort(jsu_pkg::ERR_CTRL);
        end else if (b == CH_BSLASH) begin
          scan_mode = SCAN_ESC;
        end else begin
          flush_held();
          emit_word(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
      end
      SCAN_ESC: begin
        if (b == CH_U) begin
          scan_mode = SCAN_HEX;
          hex_count = 2'd0;
          hex_accum = 16'h0000;
          hex_bad   = 1'b0;
        end else begin
          case (b)
            "\"":    mapped = {1'b1, 8'h22};
            "\\":    mapped = {1'b1, 8'h5C};
            "/":     mapped = {1'b1, 8'h2F};
            "b":     mapped = {1'b1, 8'h08};
            "f":     mapped = {1'b1, 8'h0C};
            "n":     mapped = {1'b1, 8'h0A};
            "r":     mapped = {1'b1, 8'h0D};
            "t":     mapped = {1'b1, 8'h09};
            default: mapped = 9'h000;
          endcase
          if (!mapped[8]) begin
            abort(jsu_pkg::ERR_ESC);
          end else begin
            flush_held();
            emit_word(mapped[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            scan_mode = SCAN_BODY;
          end
        end
      end
      SCAN_HEX: begin
        d = hex_nibble(b);
        if (d < 0) hex_bad = 1'b1;
        else hex_accum = {hex_accum[11:0], d[3:0]};
        if (hex_count == 2'd3) finish_unit();
        else hex_count++;
      end
      default: ;
    endcase
    if (eoi && (scan_mode == SCAN_BODY || scan_mode == SCAN_ESC || scan_mode == SCAN_HEX)) begin
      abort(scan_mode == SCAN_ESC ? jsu_pkg::ERR_END_ESC :
            (scan_mode == SCAN_HEX ? jsu_pkg::ERR_END_HEX : jsu_pkg::ERR_UNTERM));
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) pending_words.insert(pending_words.size(), step_words[i]);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_words
    word_t want;
    if (rst_n && pop && !empty) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word expected none actual byte %0h kind %0h code %0h last %0b",
                 $time, out_byte, out_kind, out_error_code, out_last);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("out_kind", 8'(want.kind), 8'(out_kind));
        check_field("out_error_code", 8'(want.code), 8'(out_error_code));
        check_field("out_last", 8'(want.last), 8'(out_last));
      end
    end
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ns, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_byte         <= b;
    in_new_string   <= ns;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_byte(b, ns, eoi);
  endtask

  task automatic send_text(input string s, input logic eoi_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == 0, eoi_at_end && i == s.len() - 1);
    end
  endtask

  task automatic send_body(input logic eoi_at_end);
    foreach (string_bytes[i]) begin
      send_byte(string_bytes[i], i == 0, eoi_at_end && i == string_bytes.size() - 1);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic void append_unicode(input logic [15:0] v);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic logic [15:0] random_unit(input int cls);
    case (cls)
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      3:       return 16'($urandom_range(16'hD800, 16'hDBFF));
      default: return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endcase
  endfunction

  function automatic void append_token();
    int         r;
    logic [7:0] c;
    string      letters;
    letters = "\"\\/bfnrt";
    r = $urandom_range(99);
    if (r < 40) begin
      c = 8'($urandom_range(8'h20, 8'hFF));
      if (c == CH_QUOTE || c == CH_BSLASH) c = "a";
      add_byte(c);
    end else if (r < 55) begin
      add_byte(CH_BSLASH);
      add_byte(letters[$urandom_range(0, 7)]);
    end else if (r < 75) begin
      append_unicode(random_unit($urandom_range(0, 4)));
    end else if (r < 90) begin
      append_unicode(random_unit(3));
      append_unicode(random_unit(4));
    end else begin
      append_unicode(16'($urandom_range(16'hD800, 16'hDFFF)));
    end
  endfunction

  function automatic logic [7:0] bad_escape_letter();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
               c == "n" || c == "r" || c == "t" || c == CH_U);
    return c;
  endfunction

  function automatic void append_bad_hex();
    int         bad_pos;
    logic [7:0] c;
    bad_pos = $urandom_range(0, 3);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    for (int i = 0; i < 4; i++) begin
      if (i == bad_pos) begin
        do begin
          c = 8'($urandom_range(0, 255));
        end while (hex_nibble(c) >= 0);
        add_byte(c);
      end else begin
        add_byte(hex_char(4'($urandom_range(0, 15))));
      end
    end
  endfunction

  task automatic send_random_string();
    int   noise;
    int   cut;
    logic eoi_last;
    string_bytes.delete();
    repeat ($urandom_range(1, 6)) append_token();
    noise = $urandom_range(99);
    eoi_last = 1'b0;
    if (noise < 6) begin
      add_byte(8'($urandom_range(0, 31)));
      repeat (2) append_token();
      add_byte(CH_QUOTE);
    end else if (noise < 12) begin
      add_byte(CH_BSLASH);
      add_byte(bad_escape_letter());
      add_byte(CH_QUOTE);
    end else if (noise < 18) begin
      append_bad_hex();
      add_byte(CH_QUOTE);
    end else if (noise < 30) begin
      // cut short: end of input inside the body, or abandoned for the next string
      cut = $urandom_range(1, string_bytes.size());
      while (string_bytes.size() > cut) void'(string_bytes.pop_back());
      eoi_last = ($urandom_range(0, 3) != 0);
    end else begin
      add_byte(CH_QUOTE);
      eoi_last = ($urandom_range(0, 3) == 0);
    end
    send_body(eoi_last);
    if (noise >= 90) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_plain_bytes();
    send_byte(8'h20, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(CH_QUOTE, 1'b0, 1'b1);
    send_byte(CH_QUOTE, 1'b1, 1'b1);
  endtask

  task automatic test_simple_escapes();
    send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0);
  endtask

  task automatic test_unicode_escapes();
    send_text("\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\"", 1'b0);
  endtask

  task automatic test_surrogates();
    send_text("\\uD83D\\uDE00\\udbff\\udfff\\uD800x\\uDC00\\uD800\\uD801\\uD802\\n\\uDBFF\"",
              1'b0);
    send_text("\\uD800\\u12G4\"", 1'b0);
    send_text("\\uD800", 1'b1);
  endtask

  task automatic test_error_cases();
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h41, 1'b0, 1'b0);
    send_byte(8'h1F, 1'b1, 1'b0);
    send_text("\\x", 1'b0);
    send_text("\\u0G00\"", 1'b0);
    send_text("ab\\", 1'b1);
    send_text("\\u12", 1'b1);
    send_text("abc", 1'b1);
    send_text("\\u0041", 1'b1);
    send_text("\"zz", 1'b1);
    send_text("\\u1", 1'b0);
  endtask

  task automatic test_random_strings(input int count);
    int goal;
    goal = live_items + count;
    while (live_items < goal) send_random_string();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    string_bytes.delete();
    repeat (12) append_unicode(16'($urandom_range(16'h0800, 16'hD7FF)));
    add_byte(CH_QUOTE);
    send_body(1'b0);
  endtask

  initial begin
    clear_decoder();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_bytes();
    test_simple_escapes();
    test_unicode_escapes();
    test_surrogates();
    test_error_cases();

    send_idle_pct = 0;  recv_stall_pct = 0;
    test_random_strings(30);
    send_idle_pct = 80; recv_stall_pct = 0;
    test_random_strings(30);
    send_idle_pct = 0;  recv_stall_pct = 80;
    test_random_strings(30);
    send_idle_pct = 24; recv_stall_pct = 24;
    test_random_strings(30);

    test_output_backpressure();

    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
